@@ hdl/rcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared constants for the RGB color distance pipeline.
// ----------------------------------------------------------------------------
package rcd_pkg;

	localparam int CH_W  = 8;
	localparam int CMD_W = 2;
	localparam int OUT_W = 17;

	localparam int DIST_FRAC_BITS_DEF = 8;

	// command codes; the unused code behaves as plain Euclidean distance
	localparam logic [CMD_W-1:0] CMD_EUCLID  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PERCEPT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SIMIL   = 2'd2;

	// perceptual weights in Q0.16, summing to 1.0
	localparam logic [15:0] W_RED   = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	// 65536 / 441.67 * 256
	localparam logic [15:0] SIM_SCALE = 16'd37986;
	localparam logic [OUT_W-1:0] SIM_ONE = 17'd65536;
	localparam logic [OUT_W-1:0] OUT_MAX = 17'h1FFFF;

endpackage

@@ hdl/rcd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_front
// Squared channel differences, optional perceptual weighting and forming of
// the fixed-point radicand for the square root chain (three stages).
// ----------------------------------------------------------------------------
module rcd_front #(
	parameter int DIST_FRAC_BITS = rcd_pkg::DIST_FRAC_BITS_DEF,
	parameter int RW = 34
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [rcd_pkg::CMD_W-1:0]  command,
	input  logic [rcd_pkg::CH_W-1:0]   first_red,
	input  logic [rcd_pkg::CH_W-1:0]   first_green,
	input  logic [rcd_pkg::CH_W-1:0]   first_blue,
	input  logic [rcd_pkg::CH_W-1:0]   second_red,
	input  logic [rcd_pkg::CH_W-1:0]   second_green,
	input  logic [rcd_pkg::CH_W-1:0]   second_blue,
	output logic                       out_valid,
	output logic                       out_sim,
	output logic [RW-1:0]              out_rad
);

	localparam int SHL = (2 * DIST_FRAC_BITS >= 16) ? 2 * DIST_FRAC_BITS - 16 : 0;
	localparam int SHR = (2 * DIST_FRAC_BITS < 16) ? 16 - 2 * DIST_FRAC_BITS : 0;

	logic [rcd_pkg::CH_W-1:0] dr, dg, db;
	logic [15:0] sq_r, sq_g, sq_b;

	logic        v_s1, wt_s1, sim_s1;
	logic [15:0] sq_r_s1, sq_g_s1, sq_b_s1;

	logic        v_s2, wt_s2, sim_s2;
	logic [31:0] wr_s2, wg_s2, wb_s2;
	logic [17:0] sum_s2;

	logic        v_s3, sim_s3;
	logic [RW-1:0] rad_s3;

	logic [31:0]   wsum;
	logic [RW-1:0] rad_next;

	always_comb begin
		dr = (first_red >= second_red) ? first_red - second_red : second_red - first_red;
		dg = (first_green >= second_green) ? first_green - second_green
			: second_green - first_green;
		db = (first_blue >= second_blue) ? first_blue - second_blue : second_blue - first_blue;
		sq_r = 16'(dr) * 16'(dr);
		sq_g = 16'(dg) * 16'(dg);
		sq_b = 16'(db) * 16'(db);
	end

	always_comb begin
		wsum = wr_s2 + wg_s2 + wb_s2;
		if (wt_s2) begin
			rad_next = RW'(wsum >> SHR) << SHL;
		end else begin
			rad_next = RW'(sum_s2) << (2 * DIST_FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wt_s1   <= (command == rcd_pkg::CMD_PERCEPT);
			sim_s1  <= (command == rcd_pkg::CMD_SIMIL);
			sq_r_s1 <= sq_r;
			sq_g_s1 <= sq_g;
			sq_b_s1 <= sq_b;

			wt_s2  <= wt_s1;
			sim_s2 <= sim_s1;
			wr_s2  <= 32'(rcd_pkg::W_RED) * 32'(sq_r_s1);
			wg_s2  <= 32'(rcd_pkg::W_GREEN) * 32'(sq_g_s1);
			wb_s2  <= 32'(rcd_pkg::W_BLUE) * 32'(sq_b_s1);
			sum_s2 <= 18'(sq_r_s1) + 18'(sq_g_s1) + 18'(sq_b_s1);

			sim_s3 <= sim_s2;
			rad_s3 <= rad_next;
		end
	end

	assign out_valid = v_s3;
	assign out_sim   = sim_s3;
	assign out_rad   = rad_s3;

endmodule

@@ hdl/rcd_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_sqrt_cell
// One digit step of the integer square root: takes the next two radicand
// bits, resolves one root bit and hands the partial state to the next cell.
// ----------------------------------------------------------------------------
module rcd_sqrt_cell #(
	parameter int RTW = 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic               in_sim,
	input  logic [2*RTW-1:0]   in_rad,
	input  logic [RTW+2:0]     in_rem,
	input  logic [RTW-1:0]     in_root,
	output logic               out_valid,
	output logic               out_sim,
	output logic [2*RTW-1:0]   out_rad,
	output logic [RTW+2:0]     out_rem,
	output logic [RTW-1:0]     out_root
);

	localparam int RW   = 2 * RTW;
	localparam int REMW = RTW + 3;

	logic [REMW-1:0] cat, trial, rem_next;
	logic            ge;

	logic            v_q, sim_q;
	logic [RW-1:0]   rad_q;
	logic [REMW-1:0] rem_q;
	logic [RTW-1:0]  root_q;

	always_comb begin
		cat      = {in_rem[REMW-3:0], in_rad[RW-1 -: 2]};
		trial    = {1'b0, in_root, 2'b01};
		ge       = (cat >= trial);
		rem_next = ge ? cat - trial : cat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sim_q  <= in_sim;
			rad_q  <= {in_rad[RW-3:0], 2'b00};
			rem_q  <= rem_next;
			root_q <= {in_root[RTW-2:0], ge};
		end
	end

	assign out_valid = v_q;
	assign out_sim   = sim_q;
	assign out_rad   = rad_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;

endmodule

@@ hdl/rcd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_back
// Similarity scaling, result selection and saturation, then the output
// register with a skid entry that decouples the pipeline from the receiver.
// ----------------------------------------------------------------------------
module rcd_back #(
	parameter int DIST_FRAC_BITS = rcd_pkg::DIST_FRAC_BITS_DEF,
	parameter int RTW = 17
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_sim,
	input  logic [RTW-1:0]             in_root,
	output logic                       en,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [rcd_pkg::OUT_W-1:0]  result_value
);

	localparam int PW = RTW + 16;
	localparam int DW = (RTW > rcd_pkg::OUT_W) ? RTW : rcd_pkg::OUT_W;

	logic          v_s1, sim_s1;
	logic [RTW-1:0] root_s1;
	logic [PW-1:0] prod_s1;

	logic                      v_s2;
	logic [rcd_pkg::OUT_W-1:0] res_s2;

	logic                      out_v_q, skid_v_q;
	logic [rcd_pkg::OUT_W-1:0] out_q, skid_q;

	logic [PW-1:0]             sub;
	logic [DW-1:0]             dx;
	logic [rcd_pkg::OUT_W-1:0] res_next;

	// pipeline moves only while the skid entry is free
	assign en = !skid_v_q;

	always_comb begin
		sub = prod_s1 >> (DIST_FRAC_BITS + 8);
		dx  = DW'(root_s1);
		if (sim_s1) begin
			res_next = (sub >= PW'(rcd_pkg::SIM_ONE)) ? '0
				: rcd_pkg::OUT_W'(PW'(rcd_pkg::SIM_ONE) - sub);
		end else if (dx > DW'(rcd_pkg::OUT_MAX)) begin
			res_next = rcd_pkg::OUT_MAX;
		end else begin
			res_next = rcd_pkg::OUT_W'(dx);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sim_s1  <= in_sim;
			root_s1 <= in_root;
			prod_s1 <= PW'(in_root) * PW'(rcd_pkg::SIM_SCALE);
			res_s2  <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
			end
			if (!out_v_q || result_ready) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= v_s2;
				end
			end else if (v_s2 && en) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result_ready) begin
			out_q <= skid_v_q ? skid_q : res_s2;
		end else if (en) begin
			skid_q <= res_s2;
		end
	end

	assign result_valid = out_v_q;
	assign result_value = out_q;

endmodule

@@ hdl/rgb_color_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_distance
// Euclidean / perceptual distance and similarity of two 8-bit RGB colors.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready) takes a command and two colors; the
// output channel (result_valid/result_ready) returns one result_value per
// item, in order. Command 0 (and 3): Euclidean distance, Q9.DIST_FRAC_BITS.
// Command 1: perceptually weighted distance, same format. Command 2:
// similarity in Q1.16, 65536 meaning identical colors, clamped at 0.
// Throughput: one item per cycle while item_ready is high. From acceptance
// to result_valid an item passes the front stages, a chain of RTW root cells
// (RTW being the root width, 17 at the default of 8 fraction bits), one root
// bit per cell, then the back stages and the output register.
// Reset clears all valid flags; no item is in flight afterwards.
// A stalled receiver holds the output register; one more result drops into a
// skid entry, and only then does item_ready fall and the pipeline freeze.
// ----------------------------------------------------------------------------
module rgb_color_distance #(
	parameter int DIST_FRAC_BITS = rcd_pkg::DIST_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  logic [rcd_pkg::CMD_W-1:0]  command,
	input  logic [rcd_pkg::CH_W-1:0]   first_red,
	input  logic [rcd_pkg::CH_W-1:0]   first_green,
	input  logic [rcd_pkg::CH_W-1:0]   first_blue,
	input  logic [rcd_pkg::CH_W-1:0]   second_red,
	input  logic [rcd_pkg::CH_W-1:0]   second_green,
	input  logic [rcd_pkg::CH_W-1:0]   second_blue,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [rcd_pkg::OUT_W-1:0]  result_value
);

	// radicand: plain sum (18 bits) shifted left by 2F, or weighted sum (32 bits)
	localparam int RW   = (18 + 2 * DIST_FRAC_BITS > 32) ? 18 + 2 * DIST_FRAC_BITS : 32;
	localparam int RTW  = RW / 2;
	localparam int REMW = RTW + 3;

	logic en;

	logic            c_valid [0:RTW];
	logic            c_sim   [0:RTW];
	logic [RW-1:0]   c_rad   [0:RTW];
	logic [REMW-1:0] c_rem   [0:RTW];
	logic [RTW-1:0]  c_root  [0:RTW];

	assign item_ready = en;

	rcd_front #(
		.DIST_FRAC_BITS(DIST_FRAC_BITS),
		.RW(RW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(item_valid),
		.command(command),
		.first_red(first_red),
		.first_green(first_green),
		.first_blue(first_blue),
		.second_red(second_red),
		.second_green(second_green),
		.second_blue(second_blue),
		.out_valid(c_valid[0]),
		.out_sim(c_sim[0]),
		.out_rad(c_rad[0])
	);

	assign c_rem[0]  = '0;
	assign c_root[0] = '0;

	for (genvar i = 0; i < RTW; i++) begin : g_cell
		rcd_sqrt_cell #(
			.RTW(RTW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(c_valid[i]),
			.in_sim(c_sim[i]),
			.in_rad(c_rad[i]),
			.in_rem(c_rem[i]),
			.in_root(c_root[i]),
			.out_valid(c_valid[i+1]),
			.out_sim(c_sim[i+1]),
			.out_rad(c_rad[i+1]),
			.out_rem(c_rem[i+1]),
			.out_root(c_root[i+1])
		);
	end

	rcd_back #(
		.DIST_FRAC_BITS(DIST_FRAC_BITS),
		.RTW(RTW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(c_valid[RTW]),
		.in_sim(c_sim[RTW]),
		.in_root(c_root[RTW]),
		.en(en),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_value(result_value)
	);

endmodule
